// ----- rtl/uer_pkg.sv -----
// ----------------------------------------------------------------------------
// uer_pkg
// Shared types and constants of the ultrasonic echo ranger: phase codes,
// status codes, register indexes, field widths and register reset values.
// ----------------------------------------------------------------------------
package uer_pkg;

    // Field widths fixed by the register map and the result format.
    localparam int TRIG_W     = 10;
    localparam int TIMEOUT_W  = 18;
    localparam int MAXECHO_W  = 18;
    localparam int SCALE_W    = 16;
    localparam int DIST_W     = 16;
    localparam int STATUS_W   = 2;
    localparam int CFG_IDX_W  = 8;
    localparam int CFG_DATA_W = 18;

    // Register reset values.
    localparam logic [TRIG_W-1:0]    TRIG_RESET    = 10'd10;
    localparam logic [TIMEOUT_W-1:0] TIMEOUT_RESET = 18'd100000;
    localparam logic [MAXECHO_W-1:0] MAXECHO_RESET = 18'd15306;
    localparam logic [SCALE_W-1:0]   SCALE_RESET   = 16'd11239;

    // Half an LSB of the Q16 scale, added before the shift for rounding.
    localparam int ROUND_HALF = 32768;

    // Register indexes on the configuration port.
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_TRIGGER_TICKS  = 8'd0,
        REG_TIMEOUT_TICKS  = 8'd1,
        REG_MAX_ECHO_TICKS = 8'd2,
        REG_MM_PER_TICK    = 8'd3
    } reg_index_t;

    // Result status codes.
    typedef enum logic [STATUS_W-1:0] {
        ST_OK      = 2'd0,
        ST_TIMEOUT = 2'd1,
        ST_RANGE   = 2'd2
    } status_t;

    // Measurement phase, one-hot.
    typedef enum logic [3:0] {
        PH_IDLE  = 4'b0001,
        PH_TRIG  = 4'b0010,
        PH_WAIT  = 4'b0100,
        PH_PULSE = 4'b1000
    } phase_t;

endpackage

// ----- rtl/ultrasonic_echo_ranger.sv -----
// ----------------------------------------------------------------------------
// ultrasonic_echo_ranger
// Trigger and echo timing controller for an ultrasonic ranging sensor.
// ----------------------------------------------------------------------------
// Usage:
// Each input beat is one microsecond tick carrying a start request and the
// sampled echo level. Every accepted input beat yields exactly one result
// beat with the trigger level, busy, done, status and distance of that tick.
// The state update and the result are computed in the cycle of acceptance
// and held in an output register, so a result appears in the cycle after its
// input beat, and one beat per cycle is taken at full rate. The single
// product pulse_count * mm_per_tick_q16 with rounding and saturation sets
// the path length between the state registers and the output register.
// When the receiver stalls, the output register keeps its beat and in_ready
// drops only while that beat is held and out_ready is low.
// The configuration port is always ready; writes are meant for idle time.
// Reset returns the phase to idle, clears the counters, empties the output
// register and loads the register defaults.
// ----------------------------------------------------------------------------
module ultrasonic_echo_ranger #(
    parameter int COUNT_BITS = 18
) (
    input  logic                           clk,
    input  logic                           rst_n,

    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [uer_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [uer_pkg::CFG_DATA_W-1:0] cfg_data,

    input  logic                           in_valid,
    output logic                           in_ready,
    input  logic                           start_req,
    input  logic                           echo_level,

    output logic                           out_valid,
    input  logic                           out_ready,
    output logic                           trigger_level,
    output logic                           busy_res,
    output logic                           done_res,
    output logic [uer_pkg::STATUS_W-1:0]   status,
    output logic [uer_pkg::DIST_W-1:0]     distance_mm
);

    // Comparison width covering both the counters and the 18-bit limits.
    localparam int CMP_W  = (COUNT_BITS > uer_pkg::TIMEOUT_W) ? COUNT_BITS
                                                              : uer_pkg::TIMEOUT_W;
    // Product width: wide enough that bits above 31 exist for saturation.
    localparam int PROD_W = ((COUNT_BITS > 16) ? COUNT_BITS : 16) + 17;
    localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

    // Configuration registers.
    logic [uer_pkg::TRIG_W-1:0]    trig_ticks_reg;
    logic [uer_pkg::TIMEOUT_W-1:0] timeout_ticks_reg;
    logic [uer_pkg::MAXECHO_W-1:0] max_echo_reg;
    logic [uer_pkg::SCALE_W-1:0]   scale_reg;

    // Measurement state.
    uer_pkg::phase_t               phase_reg, phase_next;
    logic [uer_pkg::TRIG_W-1:0]    trig_cnt_reg, trig_cnt_next;
    logic [COUNT_BITS-1:0]         wait_cnt_reg, wait_cnt_next;
    logic [COUNT_BITS-1:0]         pulse_cnt_reg, pulse_cnt_next;

    // Output register.
    logic                          out_valid_reg;
    logic                          trig_out_reg, busy_out_reg, done_out_reg;
    logic [uer_pkg::STATUS_W-1:0]  status_out_reg;
    logic [uer_pkg::DIST_W-1:0]    dist_out_reg;

    logic                          done_next;
    uer_pkg::status_t              status_next;
    logic [uer_pkg::DIST_W-1:0]    dist_next;

    logic                          in_accept;
    logic [uer_pkg::TRIG_W-1:0]    trig_len;
    logic                          timed_out;
    logic                          too_long;
    logic [PROD_W-1:0]             product;
    logic [uer_pkg::DIST_W-1:0]    dist_sat;

    assign cfg_ready = 1'b1;
    assign in_ready  = !out_valid_reg || out_ready;
    assign in_accept = in_valid && in_ready;

    // Register writes.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            trig_ticks_reg    <= uer_pkg::TRIG_RESET;
            timeout_ticks_reg <= uer_pkg::TIMEOUT_RESET;
            max_echo_reg      <= uer_pkg::MAXECHO_RESET;
            scale_reg         <= uer_pkg::SCALE_RESET;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                uer_pkg::REG_TRIGGER_TICKS:
                    trig_ticks_reg <= cfg_data[uer_pkg::TRIG_W-1:0];
                uer_pkg::REG_TIMEOUT_TICKS:
                    timeout_ticks_reg <= cfg_data[uer_pkg::TIMEOUT_W-1:0];
                uer_pkg::REG_MAX_ECHO_TICKS:
                    max_echo_reg <= cfg_data[uer_pkg::MAXECHO_W-1:0];
                uer_pkg::REG_MM_PER_TICK:
                    scale_reg <= cfg_data[uer_pkg::SCALE_W-1:0];
                default:
                    ;
            endcase
        end
    end

    // A zero trigger length behaves as one tick.
    assign trig_len = (trig_ticks_reg == '0) ? uer_pkg::TRIG_W'(1) : trig_ticks_reg;

    // Timeout covers both the programmed window and a saturated wait counter.
    assign timed_out = (CMP_W'(wait_cnt_reg) >= CMP_W'(timeout_ticks_reg))
                    || (wait_cnt_reg == COUNT_MAX);
    assign too_long  = CMP_W'(pulse_cnt_reg) > CMP_W'(max_echo_reg);

    // Distance: rounded Q16 scaling of the pulse length, saturated to 16 bits.
    assign product  = PROD_W'(pulse_cnt_reg) * PROD_W'(scale_reg)
                    + PROD_W'(uer_pkg::ROUND_HALF);
    assign dist_sat = (|product[PROD_W-1:32]) ? {uer_pkg::DIST_W{1'b1}}
                                              : product[31:16];

    // Next state and result of the current tick.
    always_comb
    begin
        phase_next     = phase_reg;
        trig_cnt_next  = trig_cnt_reg;
        wait_cnt_next  = wait_cnt_reg;
        pulse_cnt_next = pulse_cnt_reg;
        done_next      = 1'b0;
        status_next    = uer_pkg::ST_OK;
        dist_next      = '0;
        case (phase_reg)
            uer_pkg::PH_IDLE:
            begin
                if (start_req)
                begin
                    phase_next    = uer_pkg::PH_TRIG;
                    trig_cnt_next = uer_pkg::TRIG_W'(1);
                end
            end
            uer_pkg::PH_TRIG:
            begin
                if (trig_cnt_reg >= trig_len)
                begin
                    phase_next     = uer_pkg::PH_WAIT;
                    wait_cnt_next  = '0;
                    pulse_cnt_next = '0;
                end
                else
                begin
                    trig_cnt_next = trig_cnt_reg + uer_pkg::TRIG_W'(1);
                end
            end
            uer_pkg::PH_WAIT:
            begin
                if (timed_out)
                begin
                    phase_next  = uer_pkg::PH_IDLE;
                    done_next   = 1'b1;
                    status_next = uer_pkg::ST_TIMEOUT;
                end
                else
                begin
                    wait_cnt_next = wait_cnt_reg + COUNT_BITS'(1);
                    if (echo_level)
                    begin
                        phase_next     = uer_pkg::PH_PULSE;
                        pulse_cnt_next = COUNT_BITS'(1);
                    end
                end
            end
            uer_pkg::PH_PULSE:
            begin
                if (timed_out)
                begin
                    phase_next  = uer_pkg::PH_IDLE;
                    done_next   = 1'b1;
                    status_next = uer_pkg::ST_TIMEOUT;
                end
                else
                begin
                    wait_cnt_next = wait_cnt_reg + COUNT_BITS'(1);
                    if (echo_level)
                    begin
                        if (pulse_cnt_reg != COUNT_MAX)
                        begin
                            pulse_cnt_next = pulse_cnt_reg + COUNT_BITS'(1);
                        end
                    end
                    else
                    begin
                        phase_next = uer_pkg::PH_IDLE;
                        done_next  = 1'b1;
                        if (too_long)
                        begin
                            status_next = uer_pkg::ST_RANGE;
                        end
                        else
                        begin
                            dist_next = dist_sat;
                        end
                    end
                end
            end
            default:
            begin
                phase_next = uer_pkg::PH_IDLE;
            end
        endcase
    end

    // State advances once per accepted tick.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= uer_pkg::PH_IDLE;
            trig_cnt_reg  <= '0;
            wait_cnt_reg  <= '0;
            pulse_cnt_reg <= '0;
        end
        else if (in_accept)
        begin
            phase_reg     <= phase_next;
            trig_cnt_reg  <= trig_cnt_next;
            wait_cnt_reg  <= wait_cnt_next;
            pulse_cnt_reg <= pulse_cnt_next;
        end
    end

    // Output beat valid flag.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (in_accept)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // Output beat payload.
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            trig_out_reg   <= (phase_next == uer_pkg::PH_TRIG);
            busy_out_reg   <= (phase_next != uer_pkg::PH_IDLE);
            done_out_reg   <= done_next;
            status_out_reg <= status_next;
            dist_out_reg   <= dist_next;
        end
    end

    assign out_valid     = out_valid_reg;
    assign trigger_level = trig_out_reg;
    assign busy_res      = busy_out_reg;
    assign done_res      = done_out_reg;
    assign status        = status_out_reg;
    assign distance_mm   = dist_out_reg;

endmodule
